>>> sv/rrb_pkg.sv
// rrb_pkg: shared codes, widths and controller/datapath interface structs
`default_nettype none

package rrb_pkg;

    localparam int unsigned InDataW  = 16;
    localparam int unsigned InUserW  = 2;
    localparam int unsigned OutDataW = 8;
    localparam int unsigned OutUserW = 2;
    localparam int unsigned SizeW    = 7;

    localparam logic [7:0] NewlineCode = 8'h0A;

    typedef enum logic [1:0] {
        REQ_PUSH = 2'd0,
        REQ_BYTE = 2'd1,
        REQ_LINE = 2'd2,
        REQ_NONE = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_INVALID = 2'd2,
        ST_RSVD    = 2'd3
    } t_status;

    typedef struct packed {
        logic    push;
        logic    line_start;
        logic    scan_next;
        logic    pop;
        logic    addr_rd;
        logic    out_load;
        t_status out_status;
        logic    out_zero;
        logic    out_last;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic size_zero;
        logic scan_end;
        logic newline;
        logic cnt_zero;
        logic out_free;
    } t_stat;

endpackage

`default_nettype wire

>>> sv/rrb_datapath.sv
// rrb_datapath: byte store, ring pointers, scan counter and output register
`default_nettype none

module rrb_datapath #(
    parameter int unsigned RX_DEPTH = 64,
    parameter int unsigned MAX_LINE = 64
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire rrb_pkg::t_cmd                 i_cmd,
    output rrb_pkg::t_stat                     o_stat,
    input  wire logic [7:0]                    i_rx_byte,
    input  wire logic [rrb_pkg::SizeW-1:0]     i_line_size,
    input  wire logic                          i_out_ready,
    output logic                               o_out_valid,
    output logic [rrb_pkg::OutDataW-1:0]       o_out_data,
    output logic [rrb_pkg::OutUserW-1:0]       o_out_user,
    output logic                               o_out_last
);
    import rrb_pkg::*;

    localparam int unsigned PW = $clog2(RX_DEPTH);
    localparam int unsigned CW = $clog2(MAX_LINE + 1);
    localparam logic [PW-1:0] PtrLast = PW'(RX_DEPTH - 1);
    localparam logic [SizeW-1:0] MaxSize = SizeW'(MAX_LINE);

    function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
        return (p == PtrLast) ? '0 : p + 1'b1;
    endfunction

    logic [7:0]    r_mem [RX_DEPTH];
    logic [7:0]    r_rd_data;
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [PW-1:0] r_idx;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] r_size;
    logic          r_out_valid;
    logic [7:0]    r_out_data;
    t_status       r_out_status;
    logic          r_out_last;

    logic [PW-1:0] rd_addr;
    logic          full;
    logic          out_free;
    logic [CW-1:0] eff_size;

    assign n_wr_ptr = ptr_next(r_wr_ptr);
    assign n_rd_ptr = ptr_next(r_rd_ptr);
    assign full     = (n_wr_ptr == r_rd_ptr);
    assign rd_addr  = i_cmd.addr_rd ? r_rd_ptr : r_idx;
    assign out_free = !r_out_valid || i_out_ready;
    assign eff_size = (i_line_size > MaxSize) ? CW'(MAX_LINE) : i_line_size[CW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.push && !full) begin
            r_mem[r_wr_ptr] <= i_rx_byte;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr    <= '0;
            r_rd_ptr    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.push && !full) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (i_cmd.pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.line_start) begin
            r_idx  <= r_rd_ptr;
            r_cnt  <= '0;
            r_size <= eff_size;
        end else if (i_cmd.scan_next) begin
            r_idx <= ptr_next(r_idx);
            r_cnt <= r_cnt + 1'b1;
        end else if (i_cmd.pop && r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
        if (i_cmd.out_load) begin
            r_out_data   <= i_cmd.out_zero ? 8'h00 : r_rd_data;
            r_out_status <= i_cmd.out_status;
            r_out_last   <= i_cmd.out_last;
        end
    end

    always_comb begin
        o_stat.empty     = (r_wr_ptr == r_rd_ptr);
        o_stat.size_zero = (i_line_size == '0);
        o_stat.scan_end  = (r_idx == r_wr_ptr) || (r_cnt >= r_size);
        o_stat.newline   = (r_rd_data == NewlineCode);
        o_stat.cnt_zero  = (r_cnt == '0);
        o_stat.out_free  = out_free;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_out_user  = r_out_status;
    assign o_out_last  = r_out_last;

endmodule

`default_nettype wire

>>> sv/rrb_controller.sv
// rrb_controller: request sequencer for push, byte read and line read
`default_nettype none

module rrb_controller (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    input  wire logic [rrb_pkg::InUserW-1:0]   i_in_req,
    output logic                               o_in_ready,
    input  wire rrb_pkg::t_stat                i_stat,
    output rrb_pkg::t_cmd                      o_cmd
);
    import rrb_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE      = 9'b000000001,
        S_BYTE_ADDR = 9'b000000010,
        S_BYTE_DATA = 9'b000000100,
        S_SCAN_ADDR = 9'b000001000,
        S_SCAN_CMP  = 9'b000010000,
        S_POP_ADDR  = 9'b000100000,
        S_POP_DATA  = 9'b001000000,
        S_EMPTY     = 9'b010000000,
        S_BADSIZE   = 9'b100000000
    } t_state;

    t_state r_state, n_state;
    t_req   req;

    assign req        = t_req'(i_in_req);
    assign o_in_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    unique case (req)
                        REQ_PUSH: o_cmd.push = 1'b1;
                        REQ_BYTE: n_state = i_stat.empty ? S_EMPTY : S_BYTE_ADDR;
                        REQ_LINE: begin
                            if (i_stat.size_zero) begin
                                n_state = S_BADSIZE;
                            end else begin
                                o_cmd.line_start = 1'b1;
                                n_state = S_SCAN_ADDR;
                            end
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_BYTE_ADDR: begin
                o_cmd.addr_rd = 1'b1;
                n_state = S_BYTE_DATA;
            end
            S_BYTE_DATA: begin
                o_cmd.addr_rd = 1'b1;
                if (i_stat.out_free) begin
                    o_cmd.out_load   = 1'b1;
                    o_cmd.out_status = ST_OK;
                    o_cmd.out_last   = 1'b1;
                    o_cmd.pop        = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_SCAN_ADDR: begin
                n_state = i_stat.scan_end ? S_EMPTY : S_SCAN_CMP;
            end
            S_SCAN_CMP: begin
                if (i_stat.newline) begin
                    n_state = S_POP_ADDR;
                end else begin
                    o_cmd.scan_next = 1'b1;
                    n_state = S_SCAN_ADDR;
                end
            end
            S_POP_ADDR: begin
                o_cmd.addr_rd = 1'b1;
                if (!i_stat.cnt_zero) begin
                    n_state = S_POP_DATA;
                end else if (i_stat.out_free) begin
                    // terminator, drops the newline
                    o_cmd.out_load   = 1'b1;
                    o_cmd.out_status = ST_OK;
                    o_cmd.out_zero   = 1'b1;
                    o_cmd.out_last   = 1'b1;
                    o_cmd.pop        = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_POP_DATA: begin
                o_cmd.addr_rd = 1'b1;
                if (i_stat.out_free) begin
                    o_cmd.out_load   = 1'b1;
                    o_cmd.out_status = ST_OK;
                    o_cmd.pop        = 1'b1;
                    n_state = S_POP_ADDR;
                end
            end
            S_EMPTY: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load   = 1'b1;
                    o_cmd.out_status = ST_EMPTY;
                    o_cmd.out_zero   = 1'b1;
                    o_cmd.out_last   = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_BADSIZE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load   = 1'b1;
                    o_cmd.out_status = ST_INVALID;
                    o_cmd.out_zero   = 1'b1;
                    o_cmd.out_last   = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

`default_nettype wire

>>> sv/rx_ring_buffer_line_reader_unit.sv
// rx_ring_buffer_line_reader_unit: receive byte ring with byte and line readers
`default_nettype none

// Receive ring of RX_DEPTH bytes holding at most RX_DEPTH-1; a byte arriving
// when full is dropped. A push word gives no result. A line read scans the
// store from the oldest byte, one byte examined at a time (one memory read
// port with registered data), then pops and emits each byte before the
// newline, plus a terminator. One request is worked at a time; results leave
// through an output register, and a stalled output holds the sequencer. No
// clearing pass is needed after reset.
module rx_ring_buffer_line_reader_unit #(
    parameter int unsigned RX_DEPTH = 64,
    parameter int unsigned MAX_LINE = 64
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // rx_byte [7:0], line_size [14:8], zero [15]
    input  wire logic [rrb_pkg::InDataW-1:0]   s_axis_tdata,
    // req_type [1:0]
    input  wire logic [rrb_pkg::InUserW-1:0]   s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // data_byte [7:0]
    output logic [rrb_pkg::OutDataW-1:0]       m_axis_tdata,
    // status [1:0]
    output logic [rrb_pkg::OutUserW-1:0]       m_axis_tuser,
    output logic                               m_axis_tlast
);
    import rrb_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    rrb_controller u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_req   (s_axis_tuser),
        .o_in_ready (s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    rrb_datapath #(
        .RX_DEPTH (RX_DEPTH),
        .MAX_LINE (MAX_LINE)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_rx_byte   (s_axis_tdata[7:0]),
        .i_line_size (s_axis_tdata[14:8]),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata),
        .o_out_user  (m_axis_tuser),
        .o_out_last  (m_axis_tlast)
    );

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> w_stat.out_free)
        else $error("result loaded over a pending word");

    a_push_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.push |-> (s_axis_tvalid && s_axis_tready))
        else $error("push without an accepted word");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.pop |-> !w_stat.empty)
        else $error("pop from empty ring");

endmodule

`default_nettype wire
